// ----- rtl/bpcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcc_pkg
// Shared types and constants for the button short / long / chord classifier.
// ----------------------------------------------------------------------------
package bpcc_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int IDX_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int CNT_W        = 3;
    localparam int MASK_W       = 4;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CNT_W-1:0] COUNT_MAX      = 3'd7;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RESET     = 16'd1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 1'b1;

    typedef struct packed {
        logic [MASK_W-1:0] pressed_levels;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] short_mask;
        logic [MASK_W-1:0] long_mask;
        logic              chord_valid;
        logic [MASK_W-1:0] chord_mask;
    } out_item_t;

    // state of the button under service, as seen by the step unit
    typedef struct packed {
        logic             pressed;
        logic             held;
        logic             armed;
        logic [CNT_W-1:0] others;
        logic [CNT_W-1:0] count;
    } step_in_t;

    // decisions of the step unit for that button
    typedef struct packed {
        logic             held_n;
        logic             armed_n;
        logic             load_time;
        logic             long_ev;
        logic             short_ev;
        logic             pend_set;
        logic             pend_clr;
        logic             chord_fire;
        logic [CNT_W-1:0] count_n;
    } step_res_t;

endpackage

// ----- rtl/button_press_chord_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_chord_classifier
// Classifies each button scan into short, long and chord press events.
// ----------------------------------------------------------------------------
// One scan transaction gives exactly one result transaction. Buttons are
// served in index order by a single step unit (one 32-bit elapsed-time
// subtract and compare), one button per cycle: a scan is accepted in the
// idle state, stepped through each button in the run state and loaded into
// the output register in the done state once that is free. in_ready is
// high only between scans; the next scan may be taken while the previous
// result still waits in the output register. Configuration writes are
// always accepted and should be issued only while no scan is in flight.
module button_press_chord_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bpcc_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bpcc_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpcc_pkg::CFG_W-1:0]          cfg_data
);
    import bpcc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTON_COUNT - 1);

    logic [1:0]              state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [MASK_W-1:0]       levels_reg;
    logic [TIME_W-1:0]       now_reg;
    logic [CFG_W-1:0]        debounce_reg;
    logic [CFG_W-1:0]        long_reg;

    logic [BUTTON_COUNT-1:0] held_reg;
    logic [BUTTON_COUNT-1:0] armed_reg;
    logic [BUTTON_COUNT-1:0] pending_reg, pending_next;
    logic [TIME_W-1:0]       press_time_reg [BUTTON_COUNT];
    logic [CNT_W-1:0]        count_reg;

    logic [MASK_W-1:0]       short_reg, long_acc_reg, chord_acc_reg;
    logic                    chord_v_reg;

    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    logic [BUTTON_COUNT-1:0] cur_bit;
    logic [BUTTON_COUNT-1:0] involved;
    logic [CNT_W-1:0]        others;
    logic [BUTTON_COUNT-1:0] wide_levels;
    step_in_t                st;
    step_res_t               res;
    logic                    in_fire, run, done_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign run       = (state_reg == ST_RUN);
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // buttons above the input width read as released
    assign wide_levels = BUTTON_COUNT'(levels_reg);
    assign cur_bit     = BUTTON_COUNT'(1) << idx_reg;
    assign involved    = (held_reg | pending_reg) & ~cur_bit;

    always_comb
    begin
        others = '0;
        for (int j = 0; j < BUTTON_COUNT; j++)
        begin
            others = others + CNT_W'(involved[j]);
        end
    end

    assign st.pressed = wide_levels[idx_reg];
    assign st.held    = held_reg[idx_reg];
    assign st.armed   = armed_reg[idx_reg];
    assign st.others  = others;
    assign st.count   = count_reg;

    bpcc_step u_step (
        .st            (st),
        .press_time    (press_time_reg[idx_reg]),
        .now_ms        (now_reg),
        .debounce_ms   (debounce_reg),
        .long_press_ms (long_reg),
        .res           (res)
    );

    always_comb
    begin
        pending_next = pending_reg;
        priority if (res.chord_fire)
        begin
            pending_next = '0;
        end
        else if (res.pend_set)
        begin
            pending_next = pending_reg | cur_bit;
        end
        else if (res.pend_clr)
        begin
            pending_next = pending_reg & ~cur_bit;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_RUN;
            ST_RUN:  if (idx_reg == LAST_IDX) state_next = ST_DONE;
            ST_DONE: if (done_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            debounce_reg <= DEBOUNCE_RESET;
            long_reg     <= LONG_RESET;
            held_reg     <= '1;
            armed_reg    <= '0;
            pending_reg  <= '0;
            count_reg    <= '0;
            for (int k = 0; k < BUTTON_COUNT; k++)
            begin
                press_time_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_DEBOUNCE: debounce_reg <= cfg_data;
                    CFG_LONG:     long_reg     <= cfg_data;
                    default:      ;
                endcase
            end
            if (in_fire)
            begin
                idx_reg <= '0;
            end
            else if (run)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                held_reg[idx_reg]  <= res.held_n;
                armed_reg[idx_reg] <= res.armed_n;
                pending_reg        <= pending_next;
                count_reg          <= res.count_n;
                if (res.load_time)
                begin
                    press_time_reg[idx_reg] <= now_reg;
                end
            end
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan payload and event accumulators
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            levels_reg    <= in_data.pressed_levels;
            now_reg       <= in_data.now_ms;
            short_reg     <= '0;
            long_acc_reg  <= '0;
            chord_acc_reg <= '0;
            chord_v_reg   <= 1'b0;
        end
        else if (run)
        begin
            if (res.short_ev)
            begin
                short_reg <= short_reg | MASK_W'(cur_bit);
            end
            if (res.long_ev)
            begin
                long_acc_reg <= long_acc_reg | MASK_W'(cur_bit);
            end
            if (res.chord_fire)
            begin
                chord_v_reg   <= 1'b1;
                chord_acc_reg <= chord_acc_reg | MASK_W'(pending_reg | cur_bit);
            end
        end
        if (done_fire)
        begin
            out_data_reg.short_mask  <= short_reg;
            out_data_reg.long_mask   <= long_acc_reg;
            out_data_reg.chord_valid <= chord_v_reg;
            out_data_reg.chord_mask  <= chord_acc_reg;
        end
    end

    // a pending set always has a nonzero count and the count clears with it
    a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != '0) == (count_reg != '0))
        else $error("pending set and pending count disagree");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_RUN) && (idx_reg == '0))
        else $error("scan did not start at the first button");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done step");

    // a button is served once per scan, so it cannot be both short and long
    a_short_long: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.short_mask & out_data_reg.long_mask) == '0)
        else $error("button reported short and long in one scan");

endmodule

// ----- rtl/bpcc_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcc_step
// Shared per-button unit: elapsed time subtract and compare, then the
// press / release decision for the one button in service this cycle.
// ----------------------------------------------------------------------------
module bpcc_step (
    input  bpcc_pkg::step_in_t                 st,
    input  logic [bpcc_pkg::TIME_W-1:0]        press_time,
    input  logic [bpcc_pkg::TIME_W-1:0]        now_ms,
    input  logic [bpcc_pkg::CFG_W-1:0]         debounce_ms,
    input  logic [bpcc_pkg::CFG_W-1:0]         long_press_ms,
    output bpcc_pkg::step_res_t                res
);
    import bpcc_pkg::*;

    logic [TIME_W-1:0] elapsed;
    logic [CFG_W-1:0]  limit;
    logic              over;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W:0]    others_p1;

    // wraps modulo 2^32 like the timestamp
    assign elapsed   = now_ms - press_time;
    assign limit     = st.pressed ? long_press_ms : debounce_ms;
    assign over      = elapsed > {{(TIME_W-CFG_W){1'b0}}, limit};
    assign cnt_inc   = (st.count < COUNT_MAX) ? st.count + CNT_W'(1) : st.count;
    assign others_p1 = {1'b0, st.others} + (CNT_W+1)'(1);

    always_comb
    begin
        res           = '0;
        res.held_n    = st.held;
        res.armed_n   = st.armed;
        res.count_n   = st.count;
        if (st.pressed)
        begin
            if (!st.held)
            begin
                res.held_n    = 1'b1;
                res.armed_n   = 1'b1;
                res.load_time = 1'b1;
            end
            else if (st.armed && over)
            begin
                res.long_ev = 1'b1;
                res.armed_n = 1'b0;
            end
        end
        else if (st.held)
        begin
            res.held_n  = 1'b0;
            res.armed_n = 1'b0;
            if (st.armed && over)
            begin
                if (st.others == '0)
                begin
                    res.short_ev = 1'b1;
                    res.pend_clr = 1'b1;
                    res.count_n  = '0;
                end
                else
                begin
                    res.pend_set = 1'b1;
                    if ({1'b0, cnt_inc} == others_p1)
                    begin
                        res.chord_fire = 1'b1;
                        res.count_n    = '0;
                    end
                    else
                    begin
                        res.count_n = cnt_inc;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button short / long / chord press classifier.
// Scans are driven as well-formed press, tap and release sequences mixed
// with random levels. A scoreboard tracks every button and predicts the
// events of each scan. Both handshakes idle at random, and the timing
// registers are swept through several settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    import bpcc_pkg::*;

    localparam int CLK_PERIOD     = 2;
    localparam int RESET_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int DRAIN_CYCLES   = 20;
    localparam int IDLE_PCT       = 9;
    localparam int REPORT_LIMIT   = 10;
    localparam int SEND_CALM_FROM = 200;
    localparam int SEND_CALM_TO   = 350;
    localparam int RECV_CALM_FROM = 450;
    localparam int RECV_CALM_TO   = 600;
    localparam int HOLD_AT        = 320;
    localparam int HOLD_CYCLES    = 150;

    class press_scoreboard;
        logic [CFG_W-1:0]  debounce_lim;
        logic [CFG_W-1:0]  long_lim;
        logic              held       [BUTTON_COUNT];
        logic              armed      [BUTTON_COUNT];
        logic [TIME_W-1:0] press_time [BUTTON_COUNT];
        logic              pending    [BUTTON_COUNT];
        logic [CNT_W-1:0]  pend_count;
        out_item_t         expected_events [$];
        int                events_checked;
        int                mismatches;
        int                short_total;
        int                long_total;
        int                chord_total;

        function new();
            debounce_lim = DEBOUNCE_RESET;
            long_lim     = LONG_RESET;
            for (int b = 0; b < BUTTON_COUNT; b++)
            begin
                held[b]       = 1'b1;
                armed[b]      = 1'b0;
                press_time[b] = '0;
                pending[b]    = 1'b0;
            end
            pend_count     = '0;
            events_checked = 0;
            mismatches     = 0;
            short_total    = 0;
            long_total     = 0;
            chord_total    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_DEBOUNCE: debounce_lim = value;
                CFG_LONG:     long_lim     = value;
                default:      ;
            endcase
        endfunction

        // buttons are served in index order, each sees what earlier ones left
        function out_item_t classify_scan(in_item_t scan);
            out_item_t         res;
            logic [TIME_W-1:0] elapsed;
            logic              was_armed;
            int                others;
            res = '0;
            for (int b = 0; b < BUTTON_COUNT; b++)
            begin
                elapsed = scan.now_ms - press_time[b];
                if (scan.pressed_levels[b])
                begin
                    if (!held[b])
                    begin
                        held[b]       = 1'b1;
                        armed[b]      = 1'b1;
                        press_time[b] = scan.now_ms;
                    end
                    else if (armed[b] && elapsed > long_lim)
                    begin
                        res.long_mask[b] = 1'b1;
                        armed[b]         = 1'b0;
                    end
                end
                else if (held[b])
                begin
                    was_armed = armed[b];
                    held[b]   = 1'b0;
                    armed[b]  = 1'b0;
                    if (was_armed && elapsed > debounce_lim)
                    begin
                        others = 0;
                        for (int j = 0; j < BUTTON_COUNT; j++)
                            if (j != b && (held[j] || pending[j]))
                                others++;
                        if (others == 0)
                        begin
                            res.short_mask[b] = 1'b1;
                            pending[b]        = 1'b0;
                            pend_count        = '0;
                        end
                        else
                        begin
                            pending[b] = 1'b1;
                            if (pend_count < COUNT_MAX)
                                pend_count = pend_count + 1'b1;
                            if (pend_count == others + 1)
                            begin
                                res.chord_valid = 1'b1;
                                for (int j = 0; j < BUTTON_COUNT; j++)
                                begin
                                    if (pending[j])
                                        res.chord_mask[j] = 1'b1;
                                    pending[j] = 1'b0;
                                end
                                pend_count = '0;
                            end
                        end
                    end
                end
            end
            return res;
        endfunction

        function void note_scan(in_item_t scan);
            expected_events.push_back(classify_scan(scan));
        endfunction

        function void flag(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] %s mismatch at result %0d: expected %0h, got %0h",
                         $time, field, events_checked, want, got);
        endfunction

        function void check_events(out_item_t got);
            out_item_t want;
            if (expected_events.size() == 0)
            begin
                flag("unexpected result", '0, got);
            end
            else
            begin
                want = expected_events.pop_front();
                events_checked++;
                if (got.short_mask !== want.short_mask)
                    flag("short_mask", want.short_mask, got.short_mask);
                if (got.long_mask !== want.long_mask)
                    flag("long_mask", want.long_mask, got.long_mask);
                if (got.chord_valid !== want.chord_valid)
                    flag("chord_valid", want.chord_valid, got.chord_valid);
                if (got.chord_mask !== want.chord_mask)
                    flag("chord_mask", want.chord_mask, got.chord_mask);
                short_total += $countones(want.short_mask);
                long_total  += $countones(want.long_mask);
                chord_total += want.chord_valid;
            end
        endfunction

        function void finish_check();
            if (expected_events.size() != 0)
                flag("results never delivered", 0, expected_events.size());
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    press_scoreboard        sb;
    logic [MASK_W-1:0]      cur_levels = '0;
    logic [TIME_W-1:0]      scan_time  = '0;
    logic [CFG_W-1:0]       cur_debounce = DEBOUNCE_RESET;
    logic [CFG_W-1:0]       cur_long     = LONG_RESET;
    int                     scans_sent   = 0;
    int                     hold_left    = 0;
    logic                   hold_done    = 1'b0;
    int                     cycle_count  = 0;

    button_press_chord_classifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // result side: check each transaction, then choose ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_events(out_data);
        if (!hold_done && sb.events_checked == HOLD_AT)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (sb.events_checked >= RECV_CALM_FROM && sb.events_checked < RECV_CALM_TO)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_scan(input logic [MASK_W-1:0] levels, input logic [TIME_W-1:0] stamp);
        in_item_t scan;
        scan.pressed_levels = levels;
        scan.now_ms         = stamp;
        if (!(scans_sent >= SEND_CALM_FROM && scans_sent < SEND_CALM_TO) &&
            $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= scan;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_scan(scan);
        scans_sent++;
    endtask

    task automatic scan_after(input logic [MASK_W-1:0] levels, input logic [TIME_W-1:0] delta);
        scan_time = scan_time + delta;
        send_scan(levels, scan_time);
    endtask

    // steps that land on and around both thresholds, plus wide jumps
    function automatic logic [TIME_W-1:0] pick_delta();
        logic [TIME_W-1:0] deb;
        logic [TIME_W-1:0] lng;
        deb = TIME_W'(cur_debounce);
        lng = TIME_W'(cur_long);
        case ($urandom_range(9))
            0:       pick_delta = '0;
            1:       pick_delta = deb;
            2:       pick_delta = deb + 1;
            3:       pick_delta = lng;
            4:       pick_delta = lng + 1;
            5:       pick_delta = $urandom_range(deb + 2);
            6, 7:    pick_delta = $urandom_range(lng + 2);
            8:       pick_delta = $urandom_range(3);
            default: pick_delta = $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_register(idx, value);
        if (idx == CFG_DEBOUNCE)
            cur_debounce = value;
        else
            cur_long = value;
    endtask

    // press a group, hold a while, release in random order with the odd re-press
    task automatic press_gesture();
        logic [MASK_W-1:0] group;
        logic [MASK_W-1:0] chunk;
        group = MASK_W'($urandom_range(1, 15));
        while ((cur_levels & group) != group)
        begin
            chunk = group & ~cur_levels & MASK_W'($urandom_range(1, 15));
            if (chunk == '0)
                continue;
            cur_levels = cur_levels | chunk;
            scan_after(cur_levels, pick_delta());
        end
        repeat ($urandom_range(0, 2)) scan_after(cur_levels, pick_delta());
        while (cur_levels != '0)
        begin
            chunk = cur_levels & MASK_W'($urandom_range(1, 15));
            if (chunk == '0)
                continue;
            cur_levels = cur_levels & ~chunk;
            if ($urandom_range(7) == 0)
                cur_levels = cur_levels | (group & MASK_W'($urandom_range(1, 15)));
            scan_after(cur_levels, pick_delta());
        end
    endtask

    // one button tapped repeatedly while others are held, with the odd release, builds up the pending count
    task automatic tap_gesture();
        logic [MASK_W-1:0] tapper;
        tapper     = MASK_W'(1) << $urandom_range(BUTTON_COUNT - 1);
        cur_levels = cur_levels | tapper | MASK_W'($urandom_range(1, 15));
        scan_after(cur_levels, pick_delta());
        repeat ($urandom_range(3, 10))
        begin
            cur_levels = cur_levels & ~tapper;
            scan_after(cur_levels, pick_delta());
            cur_levels = cur_levels | tapper;
            if ($urandom_range(3) == 0)
                cur_levels = cur_levels & (~MASK_W'($urandom_range(1, 15)) | tapper);
            scan_after(cur_levels, pick_delta());
        end
    endtask

    task automatic run_setting(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] hold,
                               input int scans_until);
        write_reg(CFG_DEBOUNCE, debounce);
        write_reg(CFG_LONG, hold);
        while (scans_sent < scans_until)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: press_gesture();
                11, 12, 13, 14, 15:               tap_gesture();
                default:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        cur_levels = MASK_W'($urandom_range(0, 15));
                        scan_after(cur_levels, pick_delta());
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // buttons come out of reset held but unarmed
        send_scan(4'hF, 32'h0000_0000);
        send_scan(4'hF, 32'hFFFF_FFFF);
        send_scan(4'hE, 32'hFFFF_FFFF);
        // taps of button 0 across the time wrap while others stay down
        scan_time = 32'hFFFF_FF80;
        scan_after(4'hF, 0);
        scan_after(4'hE, 100);
        scan_after(4'hF, 10);
        scan_after(4'hE, 100);
        // unarmed buttons drop out, so the pending count runs up to saturation
        scan_after(4'h9, 10);
        scan_after(4'h8, 100);
        repeat (5)
        begin
            scan_after(4'h9, 10);
            scan_after(4'h8, 100);
        end
        // long press of a button that is still pending
        scan_after(4'h9, 10);
        scan_after(4'h9, 1001);
        scan_after(4'h0, 10);
        // short press of the pending button clears the chord state
        scan_after(4'h1, 10);
        scan_after(4'h0, 51);
        cur_levels = '0;

        run_setting(16'd0, 16'd0, 180);
        run_setting(16'hFFFF, 16'hFFFF, 300);
        run_setting(16'd20, 16'd80, 430);
        run_setting(16'd300, 16'd100, 540);
        run_setting(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)), 660);
        run_setting(DEBOUNCE_RESET, LONG_RESET, 800);

        in_valid <= 1'b0;
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.finish_check();

        $display("Covered %0d scans under six timing settings, %0d results checked",
                 scans_sent, sb.events_checked);
        $display("Events seen: %0d short, %0d long, %0d chord; %0d mismatches",
                 sb.short_total, sb.long_total, sb.chord_total, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
